[rtl/core/mer_pkg.sv]
package mer_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W = 24;
  localparam int PROD_W = 2 * MUL_W;

  // decision variable and slope terms
  localparam int DEC_W = 48;

  // configuration and pixel field widths
  localparam int CENTER_W = 12;
  localparam int AXIS_W = 11;
  localparam int COLOR_W = 8;
  localparam int PIX_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic load;
    logic done;
  } pix_ctl_t;

endpackage

[rtl/core/mer_mul.sv]
module mer_mul (
  input  logic                        clk,
  input  logic [mer_pkg::MUL_W-1:0]   op_a,
  input  logic [mer_pkg::MUL_W-1:0]   op_b,
  output logic [mer_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= mer_pkg::PROD_W'(op_a) * mer_pkg::PROD_W'(op_b);
  end

endmodule

[rtl/core/mer_pix.sv]
module mer_pix #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mer_pkg::pix_ctl_t                 ctl,
  input  logic [COORD_BITS-1:0]             pt_x,
  input  logic [COORD_BITS-1:0]             pt_y,
  input  logic [mer_pkg::CENTER_W-1:0]      center_x,
  input  logic [mer_pkg::CENTER_W-1:0]      center_y,
  input  logic [mer_pkg::COLOR_W-1:0]       color,
  output logic                              busy,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output logic signed [mer_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [mer_pkg::PIX_W-1:0]  pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]       color_out,
  output logic                              last_of_step,
  output logic                              ellipse_done
);

  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic                  done_r;
  logic [1:0]            cnt;
  logic                  active;
  logic                  load_out;
  logic                  use_xp;
  logic                  use_yp;
  logic [31:0]           xp_w;
  logic [31:0]           xm_w;
  logic [31:0]           yp_w;
  logic [31:0]           ym_w;

  assign xp_w = 32'(center_x) + 32'(px);
  assign xm_w = 32'(center_x) - 32'(px);
  assign yp_w = 32'(center_y) + 32'(py);
  assign ym_w = 32'(center_y) - 32'(py);

  // mirror order: (+x,+y), (+x,-y), (-x,-y), (-x,+y)
  assign use_xp = !cnt[1];
  assign use_yp = (cnt[1] == cnt[0]);

  assign load_out = active && (!pixel_valid || !pixel_stall);
  assign busy = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        active <= 1'b1;
      end else if (load_out && (&cnt)) begin
        active <= 1'b0;
      end
      if (load_out) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      px <= pt_x;
      py <= pt_y;
      done_r <= ctl.done;
      cnt <= '0;
    end else if (load_out) begin
      cnt <= cnt + 2'd1;
    end
    if (load_out) begin
      pixel_x <= use_xp ? xp_w[mer_pkg::PIX_W-1:0] : xm_w[mer_pkg::PIX_W-1:0];
      pixel_y <= use_yp ? yp_w[mer_pkg::PIX_W-1:0] : ym_w[mer_pkg::PIX_W-1:0];
      color_out <= color;
      last_of_step <= &cnt;
      ellipse_done <= done_r;
    end
  end

endmodule

[rtl/core/midpoint_ellipse_rasterizer.sv]
// A step item holds the input stalled after acceptance: setup states ST_AA, ST_BB, ST_SQ,
// ST_DISP for the axis squares, the point update, four serial mirrored pixels.
// A step that enters region two adds states ST_E_TX to ST_E_FIN for the new decision term,
// all products from the shared 24x24 multiplier; steps with no pixel return from ST_DISP or ST_R2.
// The first pixel is registered in mer_pix after ST_EMIT loads it; pixel stalls hold the input longer.
// Reset clears the sequencer and pixel valid, ends any ellipse, restores registers.
module midpoint_ellipse_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mer_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mer_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 step_valid,
  output logic                                 step_stall,
  input  logic                                 start_new,
  output logic                                 pixel_valid,
  input  logic                                 pixel_stall,
  output logic signed [mer_pkg::PIX_W-1:0]     pixel_x,
  output logic signed [mer_pkg::PIX_W-1:0]     pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]          color_out,
  output logic                                 last_of_step,
  output logic                                 ellipse_done
);

  localparam int MW = mer_pkg::MUL_W;
  localparam int PW = mer_pkg::PROD_W;
  localparam int DW = mer_pkg::DEC_W;
  localparam int SQ_W = 2 * mer_pkg::AXIS_W;

  localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_AXIS_X = 3'd2;
  localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_AXIS_Y = 3'd3;
  localparam logic [mer_pkg::CFG_IDX_W-1:0] CFG_COLOR = 3'd4;

  localparam logic [mer_pkg::COLOR_W-1:0] COLOR_RESET = 8'd15;

  localparam logic [1:0] REG_IDLE = 2'd0;
  localparam logic [1:0] REG_ONE = 2'd1;
  localparam logic [1:0] REG_TWO = 2'd2;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_AA = 5'd1;
  localparam logic [4:0] ST_BB = 5'd2;
  localparam logic [4:0] ST_SQ = 5'd3;
  localparam logic [4:0] ST_DISP = 5'd4;
  localparam logic [4:0] ST_START = 5'd5;
  localparam logic [4:0] ST_R1 = 5'd6;
  localparam logic [4:0] ST_E_TX = 5'd7;
  localparam logic [4:0] ST_E_T2L = 5'd8;
  localparam logic [4:0] ST_E_T2H = 5'd9;
  localparam logic [4:0] ST_E_TY = 5'd10;
  localparam logic [4:0] ST_E_T4L = 5'd11;
  localparam logic [4:0] ST_E_T4H = 5'd12;
  localparam logic [4:0] ST_E_T5 = 5'd13;
  localparam logic [4:0] ST_E_FIN = 5'd14;
  localparam logic [4:0] ST_R2 = 5'd15;
  localparam logic [4:0] ST_DEC = 5'd16;
  localparam logic [4:0] ST_EMIT = 5'd17;

  logic [mer_pkg::CENTER_W-1:0] center_x;
  logic [mer_pkg::CENTER_W-1:0] center_y;
  logic [mer_pkg::AXIS_W-1:0]   semi_axis_x;
  logic [mer_pkg::AXIS_W-1:0]   semi_axis_y;
  logic [mer_pkg::COLOR_W-1:0]  pixel_color;

  logic [4:0]            state;
  logic [1:0]            region;
  logic                  start_flag;
  logic                  neg;
  logic [SQ_W-1:0]       aa;
  logic [SQ_W-1:0]       bb;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [DW-1:0]         decision;
  logic [DW-1:0]         slope_x_term;
  logic [DW-1:0]         slope_y_term;
  logic [DW-1:0]         tmp;
  logic [DW-1:0]         acc;

  logic [MW-1:0]         mul_a;
  logic [MW-1:0]         mul_b;
  logic [PW-1:0]         prod;

  logic [DW-1:0]         aa_w;
  logic [DW-1:0]         bb_w;
  logic [31:0]           b_ext;
  logic [COORD_BITS:0]   tx;
  logic [COORD_BITS-1:0] tyabs;
  logic [DW-1:0]         prod_x4;
  logic [DW-1:0]         prod_lo_up;
  logic [DW-1:0]         prod_lo_up4;
  logic [DW-1:0]         d_start;
  logic [DW-1:0]         base_sel;
  logic [DW-1:0]         sx_sel;
  logic [DW-1:0]         sy_sel;
  logic [DW-1:0]         step_term;
  logic                  sx_lt_sy;
  logic                  pix_busy;
  mer_pkg::pix_ctl_t     pix_ctl;

  assign aa_w = DW'(aa);
  assign bb_w = DW'(bb);
  assign b_ext = 32'(semi_axis_y);
  assign tx = {cur_x, 1'b1};
  // (y-1)^2 wraps to 1 when y is already zero
  assign tyabs = (cur_y == '0) ? COORD_BITS'(1) : cur_y - COORD_BITS'(1);
  assign prod_x4 = {prod[PW-3:0], 2'b00};
  assign prod_lo_up = {prod[MW-1:0], {MW{1'b0}}};
  assign prod_lo_up4 = {prod[MW-3:0], {(MW + 2){1'b0}}};
  assign d_start = {bb_w[DW-3:0], 2'b00} - prod_x4 + aa_w;
  assign sx_lt_sy = $signed(slope_x_term) < $signed(slope_y_term);

  // decision update: region one adds bb + px (- py), region two aa - py (+ px)
  always_comb begin
    if (region == REG_TWO) begin
      base_sel = aa_w;
      sx_sel = neg ? slope_x_term : '0;
      sy_sel = slope_y_term;
    end else begin
      base_sel = bb_w;
      sx_sel = slope_x_term;
      sy_sel = neg ? '0 : slope_y_term;
    end
  end
  assign step_term = base_sel + sx_sel - sy_sel;

  always_comb begin
    case (state)
      ST_AA: begin
        mul_a = MW'(semi_axis_x);
        mul_b = MW'(semi_axis_x);
      end
      ST_BB: begin
        mul_a = MW'(semi_axis_y);
        mul_b = MW'(semi_axis_y);
      end
      ST_DISP: begin
        mul_a = MW'(aa);
        mul_b = MW'(semi_axis_y);
      end
      ST_E_TX: begin
        mul_a = MW'(tx);
        mul_b = MW'(tx);
      end
      ST_E_T2L: begin
        mul_a = prod[MW-1:0];
        mul_b = MW'(bb);
      end
      ST_E_T2H: begin
        mul_a = tmp[DW-1:MW];
        mul_b = MW'(bb);
      end
      ST_E_TY: begin
        mul_a = MW'(tyabs);
        mul_b = MW'(tyabs);
      end
      ST_E_T4L: begin
        mul_a = prod[MW-1:0];
        mul_b = MW'(aa);
      end
      ST_E_T4H: begin
        mul_a = tmp[DW-1:MW];
        mul_b = MW'(aa);
      end
      ST_E_T5: begin
        mul_a = MW'(aa);
        mul_b = MW'(bb);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mer_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign step_stall = !((state == ST_IDLE) && !pix_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      semi_axis_x <= '0;
      semi_axis_y <= '0;
      pixel_color <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data[mer_pkg::CENTER_W-1:0];
        CFG_CENTER_Y: center_y <= cfg_data[mer_pkg::CENTER_W-1:0];
        CFG_AXIS_X: semi_axis_x <= cfg_data[mer_pkg::AXIS_W-1:0];
        CFG_AXIS_Y: semi_axis_y <= cfg_data[mer_pkg::AXIS_W-1:0];
        CFG_COLOR: pixel_color <= cfg_data[mer_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      region <= REG_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (step_valid && !step_stall) begin
            state <= ST_AA;
          end
        end
        ST_AA: state <= ST_BB;
        ST_BB: state <= ST_SQ;
        ST_SQ: state <= ST_DISP;
        ST_DISP: begin
          if (start_flag) begin
            state <= ST_START;
          end else if (region == REG_ONE) begin
            state <= sx_lt_sy ? ST_R1 : ST_E_TX;
          end else if (region == REG_TWO) begin
            state <= ST_R2;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_START: begin
          region <= REG_ONE;
          state <= ST_EMIT;
        end
        ST_R1: state <= ST_DEC;
        ST_E_TX: state <= ST_E_T2L;
        ST_E_T2L: state <= ST_E_T2H;
        ST_E_T2H: state <= ST_E_TY;
        ST_E_TY: state <= ST_E_T4L;
        ST_E_T4L: state <= ST_E_T4H;
        ST_E_T4H: state <= ST_E_T5;
        ST_E_T5: state <= ST_E_FIN;
        ST_E_FIN: begin
          region <= REG_TWO;
          state <= ST_R2;
        end
        ST_R2: begin
          // nothing left to trace: drop the ellipse without a result
          if (cur_y == '0) begin
            region <= REG_IDLE;
            state <= ST_IDLE;
          end else begin
            state <= ST_DEC;
          end
        end
        ST_DEC: state <= ST_EMIT;
        ST_EMIT: begin
          if (cur_y == '0) begin
            region <= REG_IDLE;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (step_valid && !step_stall) begin
          start_flag <= start_new;
        end
      end
      ST_BB: aa <= prod[SQ_W-1:0];
      ST_SQ: bb <= prod[SQ_W-1:0];
      ST_START: begin
        cur_x <= '0;
        cur_y <= b_ext[COORD_BITS-1:0];
        slope_x_term <= '0;
        slope_y_term <= {prod[PW-2:0], 1'b0};
        decision <= d_start;
      end
      ST_R1: begin
        neg <= decision[DW-1];
        cur_x <= cur_x + COORD_BITS'(1);
        slope_x_term <= slope_x_term + {bb_w[DW-2:0], 1'b0};
        if (!decision[DW-1]) begin
          cur_y <= cur_y - COORD_BITS'(1);
          slope_y_term <= slope_y_term - {aa_w[DW-2:0], 1'b0};
        end
      end
      ST_E_T2L: tmp <= prod;
      ST_E_T2H: acc <= prod;
      ST_E_TY: acc <= acc + prod_lo_up;
      ST_E_T4L: tmp <= prod;
      ST_E_T4H: acc <= acc + prod_x4;
      ST_E_T5: acc <= acc + prod_lo_up4;
      ST_E_FIN: decision <= acc - prod_x4;
      ST_R2: begin
        neg <= decision[DW-1];
        if (cur_y != '0) begin
          cur_y <= cur_y - COORD_BITS'(1);
          slope_y_term <= slope_y_term - {aa_w[DW-2:0], 1'b0};
          if (decision[DW-1]) begin
            cur_x <= cur_x + COORD_BITS'(1);
            slope_x_term <= slope_x_term + {bb_w[DW-2:0], 1'b0};
          end
        end
      end
      ST_DEC: decision <= decision + {step_term[DW-3:0], 2'b00};
      default: begin
      end
    endcase
  end

  assign pix_ctl.load = (state == ST_EMIT);
  assign pix_ctl.done = (cur_y == '0);

  mer_pix #(
    .COORD_BITS (COORD_BITS)
  ) u_pix (
    .clk          (clk),
    .rst          (rst),
    .ctl          (pix_ctl),
    .pt_x         (cur_x),
    .pt_y         (cur_y),
    .center_x     (center_x),
    .center_y     (center_y),
    .color        (pixel_color),
    .busy         (pix_busy),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color_out    (color_out),
    .last_of_step (last_of_step),
    .ellipse_done (ellipse_done)
  );

endmodule

[rtl/core/mer_checker.sv]
module mer_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              step_valid,
  input logic                              step_stall,
  input logic                              pixel_valid,
  input logic                              pixel_stall,
  input logic signed [mer_pkg::PIX_W-1:0]  pixel_x,
  input logic signed [mer_pkg::PIX_W-1:0]  pixel_y,
  input logic                              last_of_step,
  input logic                              ellipse_done
);

  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  a_stalled_pixel_holds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=>
      pixel_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_of_step))
    else $error("stalled pixel changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    step_valid && !step_stall |=> step_stall)
    else $error("step taken while previous step still in work");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !last_of_step |=> pixel_valid && $stable(ellipse_done))
    else $error("mirrored pixel burst broken");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (.*);
